// ----- rtl/core/eipc_pkg.sv -----
package eipc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 65535;

  localparam int CNT_W   = 16;
  localparam int TDATA_W = 168;

  localparam logic [CNT_W-1:0] ETH_HDR_BYTES  = 16'd14;
  localparam logic [CNT_W-1:0] IPV4_MIN_END   = 16'd34;
  localparam logic [6:0]       TCP_MIN_BYTES  = 7'd20;
  localparam logic [6:0]       UDP_MIN_BYTES  = 7'd8;
  localparam logic [3:0]       IHL_MIN        = 4'd5;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [15:0] PORT_DNS   = 16'd53;
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_SSH   = 16'd22;

  localparam logic [15:0] CUSTOM_FIRST_RST  = 16'd5000;
  localparam logic [15:0] CUSTOM_SECOND_RST = 16'd5001;

  localparam logic REG_CUSTOM_FIRST  = 1'b0;
  localparam logic REG_CUSTOM_SECOND = 1'b1;

  localparam logic [3:0] STATUS_OK        = 4'd0;
  localparam logic [3:0] STATUS_SHORT_ETH = 4'd1;
  localparam logic [3:0] STATUS_ARP       = 4'd2;
  localparam logic [3:0] STATUS_IPV6      = 4'd3;
  localparam logic [3:0] STATUS_OTHER     = 4'd4;
  localparam logic [3:0] STATUS_SHORT_IP  = 4'd5;
  localparam logic [3:0] STATUS_BAD_IHL   = 4'd6;
  localparam logic [3:0] STATUS_SHORT_TCP = 4'd7;
  localparam logic [3:0] STATUS_SHORT_UDP = 4'd8;

  localparam logic [2:0] APP_DNS     = 3'd0;
  localparam logic [2:0] APP_HTTP    = 3'd1;
  localparam logic [2:0] APP_HTTPS   = 3'd2;
  localparam logic [2:0] APP_SSH     = 3'd3;
  localparam logic [2:0] APP_CUSTOM1 = 3'd4;
  localparam logic [2:0] APP_CUSTOM2 = 3'd5;
  localparam logic [2:0] APP_UNKNOWN = 3'd6;
  localparam logic [2:0] APP_NONE    = 3'd7;

  typedef struct packed {
    logic [15:0] eth_type;
    logic [3:0]  ihl;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  ttl;
    logic [15:0] total_len;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  flags;
    logic [15:0] l4_len;
  } hdr_t;

  typedef struct packed {
    hdr_t             hdr;
    logic [CNT_W-1:0] len;
  } snap_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [7:0]  time_to_live;
    logic [5:0]  ip_head_bytes;
    logic [15:0] ip_total_bytes;
    logic [15:0] src_l4_port;
    logic [15:0] dest_port;
    logic [5:0]  tcp_flag_bits;
    logic [15:0] l4_length;
    logic [2:0]  app_class;
  } record_t;

endpackage

// ----- rtl/core/eipc_capture.sv -----
module eipc_capture #(
  parameter int MAX_FRAME_BYTES = eipc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tlast,
  output logic            snap_valid,
  input  logic            snap_ready,
  output eipc_pkg::snap_t snap
);

  localparam logic [eipc_pkg::CNT_W-1:0] MaxCnt = eipc_pkg::CNT_W'(MAX_FRAME_BYTES);

  logic                        in_vld;
  logic [7:0]                  in_byte;
  logic                        in_last;
  logic [eipc_pkg::CNT_W-1:0]  byte_count;
  logic [eipc_pkg::CNT_W-1:0]  byte_count_next;
  logic [eipc_pkg::CNT_W-1:0]  len_next;
  eipc_pkg::hdr_t              hdr;
  eipc_pkg::hdr_t              hdr_next;
  logic                        snap_free;
  logic                        go;

  assign snap_free = !snap_valid || snap_ready;
  assign go        = in_vld && (!in_last || snap_free);
  assign s_tready  = !in_vld || go;

  always_comb begin
    logic [eipc_pkg::CNT_W-1:0] idx;
    logic [eipc_pkg::CNT_W-1:0] l4_start;
    logic [eipc_pkg::CNT_W-1:0] rel;
    idx             = byte_count;
    l4_start        = eipc_pkg::ETH_HDR_BYTES + eipc_pkg::CNT_W'({hdr.ihl, 2'b00});
    rel             = idx - l4_start;
    hdr_next        = hdr;
    byte_count_next = byte_count;
    len_next        = byte_count;
    if (idx < MaxCnt) begin
      byte_count_next = idx + 1'b1;
      len_next        = idx + 1'b1;
      if (idx == 16'd12 || idx == 16'd13) begin
        hdr_next.eth_type = {hdr.eth_type[7:0], in_byte};
      end else if (idx == 16'd14) begin
        hdr_next.ihl = in_byte[3:0];
      end else if (idx == 16'd16 || idx == 16'd17) begin
        hdr_next.total_len = {hdr.total_len[7:0], in_byte};
      end else if (idx == 16'd22) begin
        hdr_next.ttl = in_byte;
      end else if (idx == 16'd23) begin
        hdr_next.protocol = in_byte;
      end else if (idx >= 16'd26 && idx <= 16'd29) begin
        hdr_next.src_addr = {hdr.src_addr[23:0], in_byte};
      end else if (idx >= 16'd30 && idx <= 16'd33) begin
        hdr_next.dst_addr = {hdr.dst_addr[23:0], in_byte};
      end
      if (hdr.ihl >= eipc_pkg::IHL_MIN && idx >= l4_start && idx >= eipc_pkg::IPV4_MIN_END) begin
        if (rel <= 16'd1) begin
          hdr_next.src_port = {hdr.src_port[7:0], in_byte};
        end else if (rel <= 16'd3) begin
          hdr_next.dst_port = {hdr.dst_port[7:0], in_byte};
        end else if ((rel == 16'd4 || rel == 16'd5) && hdr.protocol == eipc_pkg::PROTO_UDP) begin
          hdr_next.l4_len = {hdr.l4_len[7:0], in_byte};
        end else if (rel == 16'd12 && hdr.protocol == eipc_pkg::PROTO_TCP) begin
          hdr_next.l4_len = {10'd0, in_byte[7:4], 2'b00};
        end else if (rel == 16'd13 && hdr.protocol == eipc_pkg::PROTO_TCP) begin
          // reorder to urg psh rst fin ack syn
          hdr_next.flags = {in_byte[5], in_byte[3], in_byte[2], in_byte[0], in_byte[4], in_byte[1]};
        end
      end
    end else begin
      len_next = MaxCnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld     <= 1'b0;
      snap_valid <= 1'b0;
      byte_count <= '0;
      hdr        <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_vld  <= 1'b1;
        in_byte <= s_tdata;
        in_last <= s_tlast;
      end else if (go) begin
        in_vld <= 1'b0;
      end
      if (go && in_last) begin
        snap_valid <= 1'b1;
        snap.hdr   <= hdr_next;
        snap.len   <= len_next;
        byte_count <= '0;
        hdr        <= '0;
      end else begin
        if (snap_ready) begin
          snap_valid <= 1'b0;
        end
        if (go) begin
          byte_count <= byte_count_next;
          hdr        <= hdr_next;
        end
      end
    end
  end

endmodule

// ----- rtl/core/eipc_classify.sv -----
module eipc_classify (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       custom_first,
  input  logic [15:0]       custom_second,
  input  logic              snap_valid,
  output logic              snap_ready,
  input  eipc_pkg::snap_t   snap,
  output logic              rec_valid,
  input  logic              rec_ready,
  output eipc_pkg::record_t rec
);

  eipc_pkg::record_t rec_next;

  assign snap_ready = !rec_valid || rec_ready;

  function automatic logic hit(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] port);
    hit = (a == port) || (b == port);
  endfunction

  always_comb begin
    logic [6:0]  l4_start;
    logic [3:0]  status;
    logic        ip_ok;
    logic        l4_ok;
    logic [15:0] sp;
    logic [15:0] dp;
    l4_start = 7'd14 + {1'b0, snap.hdr.ihl, 2'b00};
    sp       = snap.hdr.src_port;
    dp       = snap.hdr.dst_port;
    if (snap.len < eipc_pkg::ETH_HDR_BYTES) begin
      status = eipc_pkg::STATUS_SHORT_ETH;
    end else if (snap.hdr.eth_type == eipc_pkg::ETYPE_ARP) begin
      status = eipc_pkg::STATUS_ARP;
    end else if (snap.hdr.eth_type == eipc_pkg::ETYPE_IPV6) begin
      status = eipc_pkg::STATUS_IPV6;
    end else if (snap.hdr.eth_type != eipc_pkg::ETYPE_IPV4) begin
      status = eipc_pkg::STATUS_OTHER;
    end else if (snap.len < eipc_pkg::IPV4_MIN_END) begin
      status = eipc_pkg::STATUS_SHORT_IP;
    end else if (snap.hdr.ihl < eipc_pkg::IHL_MIN || snap.len < 16'(l4_start)) begin
      status = eipc_pkg::STATUS_BAD_IHL;
    end else if (snap.hdr.protocol == eipc_pkg::PROTO_TCP &&
                 snap.len < 16'(l4_start + eipc_pkg::TCP_MIN_BYTES)) begin
      status = eipc_pkg::STATUS_SHORT_TCP;
    end else if (snap.hdr.protocol == eipc_pkg::PROTO_UDP &&
                 snap.len < 16'(l4_start + eipc_pkg::UDP_MIN_BYTES)) begin
      status = eipc_pkg::STATUS_SHORT_UDP;
    end else begin
      status = eipc_pkg::STATUS_OK;
    end
    ip_ok = status == eipc_pkg::STATUS_OK || status == eipc_pkg::STATUS_SHORT_TCP ||
            status == eipc_pkg::STATUS_SHORT_UDP;
    l4_ok = status == eipc_pkg::STATUS_OK &&
            (snap.hdr.protocol == eipc_pkg::PROTO_TCP || snap.hdr.protocol == eipc_pkg::PROTO_UDP);

    rec_next           = '0;
    rec_next.status    = status;
    rec_next.app_class = eipc_pkg::APP_NONE;
    if (ip_ok) begin
      rec_next.ip_protocol    = snap.hdr.protocol;
      rec_next.source_address = snap.hdr.src_addr;
      rec_next.dest_address   = snap.hdr.dst_addr;
      rec_next.time_to_live   = snap.hdr.ttl;
      rec_next.ip_head_bytes  = {snap.hdr.ihl, 2'b00};
      rec_next.ip_total_bytes = snap.hdr.total_len;
    end
    if (l4_ok) begin
      rec_next.src_l4_port = sp;
      rec_next.dest_port   = dp;
      rec_next.l4_length   = snap.hdr.l4_len;
      if (snap.hdr.protocol == eipc_pkg::PROTO_TCP) begin
        rec_next.tcp_flag_bits = snap.hdr.flags;
      end
      if (hit(sp, dp, eipc_pkg::PORT_DNS)) begin
        rec_next.app_class = eipc_pkg::APP_DNS;
      end else if (hit(sp, dp, eipc_pkg::PORT_HTTP)) begin
        rec_next.app_class = eipc_pkg::APP_HTTP;
      end else if (hit(sp, dp, eipc_pkg::PORT_HTTPS)) begin
        rec_next.app_class = eipc_pkg::APP_HTTPS;
      end else if (hit(sp, dp, eipc_pkg::PORT_SSH)) begin
        rec_next.app_class = eipc_pkg::APP_SSH;
      end else if (hit(sp, dp, custom_first)) begin
        rec_next.app_class = eipc_pkg::APP_CUSTOM1;
      end else if (hit(sp, dp, custom_second)) begin
        rec_next.app_class = eipc_pkg::APP_CUSTOM2;
      end else begin
        rec_next.app_class = eipc_pkg::APP_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      rec_valid <= 1'b1;
      rec       <= rec_next;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/eth_ipv4_l4_header_classifier_top.sv -----
// Ethernet / IPv4 / TCP-UDP header classifier.
// Input stream: one frame byte per word on s_tdata, s_tlast on the final
// byte of a frame. Output stream: one classification record per frame,
// given on the word after the frame's final byte has passed through.
// A new byte is accepted every cycle while s_tready is high. After the
// final byte is accepted it passes through the input register, then the
// snapshot register, then the output register that raises m_tvalid.
// While a record waits on m_tready, bytes of the next frame keep flowing
// into the capture stage; s_tready drops only when the next frame's final
// byte finds both the snapshot and output registers full.
// Frames longer than MAX_FRAME_BYTES stop capturing there and report that
// length. The two custom port registers are written on cfg_we with
// cfg_index; write them only while no frame is in flight.
// Reset (rst, synchronous) empties the pipeline, clears the frame state and
// loads the custom ports with 5000 and 5001.
module eth_ipv4_l4_header_classifier_top #(
  parameter int MAX_FRAME_BYTES = eipc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // frame_byte
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status, ip_protocol, source_address, dest_address, time_to_live,
  // ip_head_bytes, ip_total_bytes, src_l4_port, dest_port, tcp_flag_bits,
  // l4_length, app_class, zero pad
  output logic [eipc_pkg::TDATA_W-1:0] m_tdata,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [15:0]                  cfg_data
);

  logic              custom_first;
  logic [15:0]       port_first;
  logic [15:0]       port_second;
  logic              snap_valid;
  logic              snap_ready;
  eipc_pkg::snap_t   snap;
  eipc_pkg::record_t rec;

  assign custom_first = cfg_index == eipc_pkg::REG_CUSTOM_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_first  <= eipc_pkg::CUSTOM_FIRST_RST;
      port_second <= eipc_pkg::CUSTOM_SECOND_RST;
    end else if (cfg_we) begin
      if (custom_first) begin
        port_first <= cfg_data;
      end else if (cfg_index == eipc_pkg::REG_CUSTOM_SECOND) begin
        port_second <= cfg_data;
      end
    end
  end

  eipc_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_capture (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap      (snap)
  );

  eipc_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .custom_first (port_first),
    .custom_second(port_second),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .rec_valid    (m_tvalid),
    .rec_ready    (m_tready),
    .rec          (rec)
  );

  assign m_tdata = {5'd0, rec.app_class, rec.l4_length, rec.tcp_flag_bits, rec.dest_port,
                    rec.src_l4_port, rec.ip_total_bytes, rec.ip_head_bytes, rec.time_to_live,
                    rec.dest_address, rec.source_address, rec.ip_protocol, rec.status};

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && snap_valid))
    else $error("input stalled while pipeline has room");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rec.status <= eipc_pkg::STATUS_SHORT_UDP)
    else $error("status code out of range");

  a_no_ports_unless_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && rec.status != eipc_pkg::STATUS_OK) |->
      (rec.app_class == eipc_pkg::APP_NONE && rec.src_l4_port == 16'd0 &&
       rec.dest_port == 16'd0))
    else $error("transport fields present on a failed frame");

  a_snapshot_moves: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("snapshot not moved into free output register");

endmodule
